### sv/bst_pkg.sv
// Shared types and constants for the button stopwatch timekeeper.
package bst_pkg;

    localparam int unsigned TickW  = 7;
    localparam int unsigned HoldW  = 16;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [9:0] MsLimit   = 10'd999;
    localparam logic [5:0] SecLimit  = 6'd59;
    localparam logic [5:0] MinLimit  = 6'd59;
    localparam logic [6:0] HourLimit = 7'd99;

    localparam logic [TickW-1:0] TickMsReset    = 7'd10;
    localparam logic [HoldW-1:0] LongPressReset = 16'd1000;
    localparam logic [HoldW-1:0] HoldMax        = 16'hFFFF;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TICK_MS    = 2'd0,
        CFG_LONG_PRESS = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [9:0] millis;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [6:0] hours;
    } time_t;

endpackage

### sv/bst_time_step.sv
// Advances the clock value by one tick with cascaded carries.
module bst_time_step (
    input  bst_pkg::time_t               cur,
    input  logic [bst_pkg::TickW-1:0]    tick_ms,
    output bst_pkg::time_t               nxt
);
    import bst_pkg::*;

    logic [10:0] ms_sum;
    logic        sec_carry;
    logic        min_carry;
    logic        hour_carry;

    always_comb
    begin
        ms_sum     = {1'b0, cur.millis} + {4'b0, tick_ms};
        sec_carry  = (ms_sum > {1'b0, MsLimit});
        min_carry  = sec_carry && (cur.seconds == SecLimit);
        hour_carry = min_carry && (cur.minutes == MinLimit);

        nxt = cur;
        // overflowing millis restart at zero, remainder dropped
        nxt.millis = sec_carry ? '0 : ms_sum[9:0];
        if (sec_carry)
        begin
            nxt.seconds = min_carry ? '0 : cur.seconds + 6'd1;
        end
        if (min_carry)
        begin
            nxt.minutes = hour_carry ? '0 : cur.minutes + 6'd1;
        end
        if (hour_carry)
        begin
            nxt.hours = (cur.hours == HourLimit) ? '0 : cur.hours + 7'd1;
        end
    end

endmodule

### sv/button_stopwatch_timekeeper.sv
// Top level of the button stopwatch timekeeper.
// The word for a tick shows on the outputs in the cycle after acceptance.
// Throughput: one tick word per cycle; the clock state register doubles as the result
// register, so a new word is taken whenever the result is free or being taken.
// Reset (rst_n, async, active low): clock cleared, paused, no hold, tick_ms = 10,
// long_press_ms = 1000, no result pending.
module button_stopwatch_timekeeper (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [bst_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [bst_pkg::CfgW-1:0]       cfg_data,
    // tick word in
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           button_held,
    // time word out
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [9:0]                     millis,
    output logic [5:0]                     seconds,
    output logic [5:0]                     minutes,
    output logic [6:0]                     hours,
    output logic                           running
);
    import bst_pkg::*;

    // configuration
    logic [TickW-1:0] tick_ms_reg;
    logic [HoldW-1:0] long_press_reg;

    // stopwatch state; also holds the last result word
    time_t            time_reg;
    time_t            time_next;
    time_t            time_stepped;
    logic             run_reg;
    logic             run_next;
    logic [HoldW-1:0] hold_reg;
    logic [HoldW-1:0] hold_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic             accept;
    logic             release_evt;
    logic             long_press;
    logic [HoldW:0]   hold_sum;

    // a word is taken when the result slot is empty or drains this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    bst_time_step u_step (
        .cur     (time_reg),
        .tick_ms (tick_ms_reg),
        .nxt     (time_stepped)
    );

    always_comb
    begin
        // press duration, saturating
        hold_sum    = {1'b0, hold_reg} + {{(HoldW + 1 - TickW){1'b0}}, tick_ms_reg};
        release_evt = !button_held && (hold_reg != '0);
        long_press  = release_evt && (hold_reg > long_press_reg);

        if (button_held)
        begin
            hold_next = hold_sum[HoldW] ? HoldMax : hold_sum[HoldW-1:0];
        end
        else
        begin
            hold_next = '0;
        end

        // long press clears and pauses; short press toggles
        if (long_press)
        begin
            run_next = 1'b0;
        end
        else if (release_evt)
        begin
            run_next = !run_reg;
        end
        else
        begin
            run_next = run_reg;
        end

        // toggle-to-run advances on the release tick itself
        if (long_press)
        begin
            time_next = '0;
        end
        else if (run_next)
        begin
            time_next = time_stepped;
        end
        else
        begin
            time_next = time_reg;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ms_reg    <= TickMsReset;
            long_press_reg <= LongPressReset;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TICK_MS:    tick_ms_reg    <= cfg_data[TickW-1:0];
                CFG_LONG_PRESS: long_press_reg <= cfg_data[HoldW-1:0];
                default:        ; // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= '0;
            run_reg       <= 1'b0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                time_reg <= time_next;
                run_reg  <= run_next;
                hold_reg <= hold_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign millis    = time_reg.millis;
    assign seconds   = time_reg.seconds;
    assign minutes   = time_reg.minutes;
    assign hours     = time_reg.hours;
    assign running   = run_reg;

    // clock fields never leave their ranges
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        (time_reg.millis <= MsLimit) && (time_reg.seconds <= SecLimit) &&
        (time_reg.minutes <= MinLimit) && (time_reg.hours <= HourLimit))
        else $error("clock field out of range");

    // every accepted word leaves a pending result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted word produced no result");

    // a long press clears the clock and pauses it
    a_long_press: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !button_held && (hold_reg > long_press_reg)
        |=> (time_reg == '0) && !run_reg && (hold_reg == '0))
        else $error("long press did not clear");

    // a paused clock with the button held does not move
    a_paused_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && button_held && !run_reg |=> $stable(time_reg) && !run_reg)
        else $error("paused clock moved");

endmodule

### verif/testbench.sv
// Self-checking testbench for the button stopwatch timekeeper.
`timescale 1ns / 1ps

module testbench;
    import bst_pkg::*;

    // Spare register indexes: writes there must leave both registers alone.
    localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;
    localparam int IdlePct   = 13;
    localparam int PrintCap  = 20;

    typedef struct packed {
        time_t stamp;
        logic  running;
    } clock_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgW-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic button_held;
    logic out_valid;
    logic out_ready;
    logic [9:0] millis;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [6:0] hours;
    logic running;

    // Stimulus waiting for the driver, and time words still owed by the block.
    logic pending_ticks[$];
    clock_word_t owed_times[$];

    // Shadow copy of the stopwatch state and its two registers.
    logic [TickW-1:0] tick_cfg;
    logic [HoldW-1:0] long_cfg;
    logic [9:0] sw_ms;
    logic [5:0] sw_sec;
    logic [5:0] sw_min;
    logic [6:0] sw_hr;
    logic [HoldW-1:0] sw_hold;
    logic sw_run;

    int accepted_ticks = 0;
    int error_count = 0;
    logic draining;
    logic calm;

    // A stretch of several hundred words with no idling on either side.
    assign calm = (accepted_ticks >= 300) && (accepted_ticks < 700);

    always #1 clk = ~clk;

    button_stopwatch_timekeeper i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .button_held (button_held),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .millis      (millis),
        .seconds     (seconds),
        .minutes     (minutes),
        .hours       (hours),
        .running     (running)
    );

    task automatic flag_mismatch(input string field, input int got, input int want);
        if (error_count < PrintCap)
            $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // Clock advance with cascaded carries; the millisecond remainder is dropped
    // on overflow.
    task automatic advance_clock();
        logic [10:0] ms_sum;
        ms_sum = sw_ms + tick_cfg;
        if (ms_sum <= MsLimit) begin
            sw_ms = ms_sum[9:0];
            return;
        end
        sw_ms = '0;
        if (sw_sec != SecLimit) begin
            sw_sec++;
            return;
        end
        sw_sec = '0;
        if (sw_min != MinLimit) begin
            sw_min++;
            return;
        end
        sw_min = '0;
        sw_hr = (sw_hr == HourLimit) ? '0 : sw_hr + 7'd1;
    endtask

    // One accepted tick: judge the hold on release, then advance if running,
    // and owe the resulting time word.
    task automatic predict_time(input logic held);
        logic [HoldW:0] hold_sum;
        logic wipe;
        clock_word_t word;
        wipe = 1'b0;
        if (held) begin
            hold_sum = sw_hold + tick_cfg;
            sw_hold = (hold_sum > HoldMax) ? HoldMax : hold_sum[HoldW-1:0];
        end else if (sw_hold != '0) begin
            if (sw_hold > long_cfg)
                wipe = 1'b1;
            else
                sw_run = ~sw_run;
            sw_hold = '0;
        end
        if (wipe) begin
            sw_ms  = '0;
            sw_sec = '0;
            sw_min = '0;
            sw_hr  = '0;
            sw_run = 1'b0;
        end else if (sw_run) begin
            advance_clock();
        end
        word.stamp.millis  = sw_ms;
        word.stamp.seconds = sw_sec;
        word.stamp.minutes = sw_min;
        word.stamp.hours   = sw_hr;
        word.running       = sw_run;
        owed_times.push_back(word);
    endtask

    task automatic check_time_word();
        clock_word_t want;
        if (owed_times.size() == 0) begin
            flag_mismatch("time word with none owed", millis, 0);
            return;
        end
        want = owed_times.pop_front();
        if (millis !== want.stamp.millis)
            flag_mismatch("millis", millis, want.stamp.millis);
        if (seconds !== want.stamp.seconds)
            flag_mismatch("seconds", seconds, want.stamp.seconds);
        if (minutes !== want.stamp.minutes)
            flag_mismatch("minutes", minutes, want.stamp.minutes);
        if (hours !== want.stamp.hours)
            flag_mismatch("hours", hours, want.stamp.hours);
        if (running !== want.running)
            flag_mismatch("running", running, want.running);
    endtask

    // Driver: keeps valid and the level steady until taken, idles at random,
    // and now and then holds off until every owed word has come back.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid    <= 1'b0;
            button_held <= 1'b0;
            draining    <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_time(button_held);
                accepted_ticks++;
                if (accepted_ticks % 500 == 250)
                    draining <= 1'b1;
            end else if (draining && !in_valid && owed_times.size() == 0) begin
                draining <= 1'b0;
            end
            if (!in_valid || in_ready) begin
                if (pending_ticks.size() != 0 && !draining
                        && (calm || $urandom_range(99) >= IdlePct)) begin
                    in_valid    <= 1'b1;
                    button_held <= pending_ticks.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls at random outside the calm stretch and checks every word taken.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready)
                check_time_word();
            out_ready <= calm || ($urandom_range(99) >= IdlePct);
        end
    end

    // Register write; the shadow copy follows, spare indexes change nothing.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_TICK_MS)
            tick_cfg = value[TickW-1:0];
        else if (idx == CFG_LONG_PRESS)
            long_cfg = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_released(input int count);
        repeat (count) pending_ticks.push_back(1'b0);
    endtask

    task automatic queue_press(input int len);
        repeat (len) pending_ticks.push_back(1'b1);
        pending_ticks.push_back(1'b0);
    endtask

    // Mostly well-formed presses around the long-press boundary for the
    // current registers, with some random level noise in between.
    task automatic queue_button_traffic(input int count);
        int added;
        int gap;
        int press;
        int thr;
        int noise;
        added = 0;
        while (added < count) begin
            if ($urandom_range(9) == 0) begin
                noise = $urandom_range(1, 8);
                repeat (noise) pending_ticks.push_back(1'($urandom_range(1)));
                added += noise;
            end
            gap = $urandom_range(12);
            queue_released(gap);
            thr = (tick_cfg == '0) ? 8 : long_cfg / tick_cfg;
            if (thr > 40)
                thr = 40;
            if (thr < 1)
                thr = 1;
            case ($urandom_range(9))
                6, 7:    press = thr;
                8, 9:    press = thr + 1;
                default: press = $urandom_range(1, thr);
            endcase
            queue_press(press);
            added += gap + press + 1;
        end
    endtask

    // Registers are only touched once the block has drained.
    task automatic wait_idle();
        while (pending_ticks.size() != 0 || in_valid || owed_times.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_TICK_MS;
        cfg_data  = '0;
        tick_cfg  = TickMsReset;
        long_cfg  = LongPressReset;
        sw_ms     = '0;
        sw_sec    = '0;
        sw_min    = '0;
        sw_hr     = '0;
        sw_hold   = '0;
        sw_run    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: start, run a tick, press while running, stop.
        queue_released(1);
        queue_press(1);
        queue_released(1);
        queue_press(1);
        wait_idle();

        // Tick with junk in the upper data bits, spare indexes ignored.
        write_reg(CFG_TICK_MS, 16'hFF64);
        write_reg(CFG_LONG_PRESS, 16'd300);
        write_reg(CfgSpareLo, 16'hFFFF);
        write_reg(CfgSpareHi, 16'h0001);
        // Hold exactly at the threshold toggles and advances on release,
        // then the millisecond overflow carries a second, then a long press clears.
        queue_press(3);
        queue_released(9);
        queue_press(4);
        wait_idle();

        write_reg(CFG_TICK_MS, 16'd10);
        write_reg(CFG_LONG_PRESS, 16'd50);
        queue_button_traffic(120);
        wait_idle();

        // Smallest tick; with no threshold every press clears.
        write_reg(CFG_TICK_MS, 16'd1);
        write_reg(CFG_LONG_PRESS, 16'd0);
        queue_button_traffic(30);
        wait_idle();
        write_reg(CFG_LONG_PRESS, 16'd4);
        queue_button_traffic(60);
        wait_idle();

        // Largest tick and threshold: a saturated hold still toggles.
        write_reg(CFG_TICK_MS, 16'd127);
        write_reg(CFG_LONG_PRESS, 16'hFFFF);
        queue_button_traffic(40);
        queue_press(520);
        queue_button_traffic(20);
        wait_idle();

        // Zero tick: holds never build and the clock stands still.
        write_reg(CFG_TICK_MS, 16'd0);
        write_reg(CFG_LONG_PRESS, 16'd0);
        queue_button_traffic(30);
        wait_idle();

        // Oversized tick; saturated hold just above the threshold clears.
        write_reg(CFG_TICK_MS, 16'd113);
        write_reg(CFG_LONG_PRESS, 16'hFFFE);
        queue_press(585);
        queue_button_traffic(30);
        wait_idle();

        repeat (3) begin
            write_reg(CFG_TICK_MS, 16'($urandom_range(1, 127)));
            write_reg(CFG_LONG_PRESS, 16'($urandom_range(0, 20 * tick_cfg)));
            queue_button_traffic(30);
            wait_idle();
        end

        // Free run at 8 ticks a second: a string of second carries.
        write_reg(CFG_TICK_MS, 16'd127);
        write_reg(CFG_LONG_PRESS, 16'hFFFF);
        if (!sw_run)
            queue_press(1);
        queue_released(80);
        queue_press(1);
        wait_idle();

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

endmodule

### files.f
sv/bst_pkg.sv
sv/bst_time_step.sv
sv/button_stopwatch_timekeeper.sv
verif/testbench.sv
